### design/perlin_gradient_noise_2d_core_assert.svh
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_core_assert: assertion macros
// Concurrent checks on clk with synchronous rst; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERLIN_GRADIENT_NOISE_2D_CORE_ASSERT_SVH
`define PERLIN_GRADIENT_NOISE_2D_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PGN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgn check failed");
`define PGN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgn check failed");
`else
`define PGN_ASSERT_NOW(label, ante, cons)
`define PGN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/pgn_pkg.sv
// ----------------------------------------------------------------------------
// pgn_pkg
// Constants and helper functions for the 2D gradient noise core.
// ----------------------------------------------------------------------------
package pgn_pkg;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = -64'sd693598669;
  localparam longint SIN_C5 = 64'sd85569278;
  localparam longint SIN_C7 = -64'sd5026937;
  localparam longint SIN_C9 = 64'sd172273;

  localparam int ONE_Q16 = 65536;
  localparam int DOT_RND = 32768;

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // sin(pi/2 * t / 2^16) in Q16; elaboration-time table builder
  function automatic longint quarter_sin(input longint t);
    longint t2;
    longint acc;
    longint s;
    t2 = (t * t) >>> 16;
    acc = SIN_C9;
    acc = SIN_C7 + ((acc * t2) >>> 16);
    acc = SIN_C5 + ((acc * t2) >>> 16);
    acc = SIN_C3 + ((acc * t2) >>> 16);
    acc = SIN_C1 + ((acc * t2) >>> 16);
    s = (acc * t + (64'sd1 <<< 29)) >>> 30;
    if (s < 0) s = 0;
    if (s > ONE_Q16) s = ONE_Q16;
    return s;
  endfunction

endpackage

### design/pgn_hash.sv
// ----------------------------------------------------------------------------
// pgn_hash
// Cell corner split and four-stage multiply-rotate-xor corner hash.
// ----------------------------------------------------------------------------
module pgn_hash #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic signed [31:0]          coord_x,
  input  logic signed [31:0]          coord_y,
  output logic                        valid,
  output logic [3:0][31:0]            hash,
  output logic [FRAC_BITS-1:0]        fx,
  output logic [FRAC_BITS-1:0]        fy
);

  logic signed [31:0] x0_w, y0_w;
  logic [31:0] cx0, cx1, cy0, cy1;
  logic [31:0] a0, a1, cy0_2, cy1_2;
  logic [3:0][31:0] a3, b3;
  logic [3:0] vld;
  logic [3:0][FRAC_BITS-1:0] fxd, fyd;

  assign x0_w = coord_x >>> FRAC_BITS;
  assign y0_w = coord_y >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cx0 <= x0_w;
      cx1 <= x0_w + 32'sd1;
      cy0 <= y0_w;
      cy1 <= y0_w + 32'sd1;
      fxd <= {fxd[2:0], coord_x[FRAC_BITS-1:0]};
      fyd <= {fyd[2:0], coord_y[FRAC_BITS-1:0]};

      a0    <= cx0 * pgn_pkg::HASH_MUL_A;
      a1    <= cx1 * pgn_pkg::HASH_MUL_A;
      cy0_2 <= cy0;
      cy1_2 <= cy1;

      for (int k = 0; k < 4; k++) begin
        a3[k] <= k[0] ? a1 : a0;
        b3[k] <= ((k[1] ? cy1_2 : cy0_2) ^ pgn_pkg::rotl16(k[0] ? a1 : a0))
                 * pgn_pkg::HASH_MUL_B;
        hash[k] <= (a3[k] ^ pgn_pkg::rotl16(b3[k])) * pgn_pkg::HASH_MUL_C;
      end
    end
  end

  assign valid = vld[3];
  assign fx    = fxd[3];
  assign fy    = fyd[3];

endmodule

### design/pgn_grad.sv
// ----------------------------------------------------------------------------
// pgn_grad
// Gradient lookup from hash angle bits and corner dot products.
// ----------------------------------------------------------------------------
module pgn_grad #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  logic                               in_valid,
  input  logic [3:0][31:0]                   hash,
  input  logic [FRAC_BITS-1:0]               fx_in,
  input  logic [FRAC_BITS-1:0]               fy_in,
  output logic                               valid,
  output logic signed [3:0][FRAC_BITS+2:0]   dot,
  output logic [FRAC_BITS-1:0]               fx,
  output logic [FRAC_BITS-1:0]               fy
);

  localparam int RB  = ANGLE_BITS - 2;
  localparam int QN  = 1 << RB;
  localparam int TSH = 16 - RB;
  localparam int DW  = FRAC_BITS + 1;
  localparam int PW  = DW + 18;
  localparam int NW  = FRAC_BITS + 3;

  logic [16:0] sin_tab [QN+1];

  for (genvar i = 0; i <= QN; i++) begin : g_tab
    assign sin_tab[i] = 17'(pgn_pkg::quarter_sin(longint'(i) <<< TSH));
  end

  logic [3:0][ANGLE_BITS-1:0] idx;
  logic [3:0][RB-1:0] rem;
  logic signed [3:0][17:0] gx_w, gy_w, gx, gy;
  logic signed [3:0][PW-1:0] px, py;
  logic signed [3:0][PW:0] sum;
  logic signed [3:0][DW-1:0] dx, dy;
  logic [16:0] sv [4];
  logic [16:0] cv [4];
  logic [2:0] vld;
  logic [2:0][FRAC_BITS-1:0] fxd, fyd;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      idx[k] = hash[k][31 -: ANGLE_BITS];
      rem[k] = idx[k][RB-1:0];
      sv[k]  = sin_tab[{1'b0, rem[k]}];
      cv[k]  = sin_tab[(RB+1)'(QN) - {1'b0, rem[k]}];
      if (idx[k][ANGLE_BITS-1] ^ idx[k][ANGLE_BITS-2]) begin
        gx_w[k] = idx[k][ANGLE_BITS-2] ? -$signed({1'b0, sv[k]}) : -$signed({1'b0, cv[k]});
      end else begin
        gx_w[k] = idx[k][ANGLE_BITS-2] ? $signed({1'b0, sv[k]}) : $signed({1'b0, cv[k]});
      end
      if (idx[k][ANGLE_BITS-1]) begin
        gy_w[k] = idx[k][ANGLE_BITS-2] ? -$signed({1'b0, cv[k]}) : -$signed({1'b0, sv[k]});
      end else begin
        gy_w[k] = idx[k][ANGLE_BITS-2] ? $signed({1'b0, cv[k]}) : $signed({1'b0, sv[k]});
      end
      dx[k]  = $signed({k[0], fxd[0]});
      dy[k]  = $signed({k[1], fyd[0]});
      sum[k] = (PW+1)'($signed(px[k])) + (PW+1)'($signed(py[k]))
               + (PW+1)'(pgn_pkg::DOT_RND);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      fxd <= {fxd[1:0], fx_in};
      fyd <= {fyd[1:0], fy_in};
      gx  <= gx_w;
      gy  <= gy_w;
      for (int k = 0; k < 4; k++) begin
        px[k]  <= $signed(dx[k]) * $signed(gx[k]);
        py[k]  <= $signed(dy[k]) * $signed(gy[k]);
        dot[k] <= NW'($signed(sum[k]) >>> 16);
      end
    end
  end

  assign valid = vld[2];
  assign fx    = fxd[2];
  assign fy    = fyd[2];

endmodule

### design/pgn_interp.sv
// ----------------------------------------------------------------------------
// pgn_interp
// Linear interpolation along x then y, Q16 conversion and saturation.
// ----------------------------------------------------------------------------
module pgn_interp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  logic                               in_valid,
  input  logic signed [3:0][FRAC_BITS+2:0]   dot,
  input  logic [FRAC_BITS-1:0]               fx,
  input  logic [FRAC_BITS-1:0]               fy,
  output logic                               valid,
  output logic signed [17:0]                 noise_value
);

  localparam int NW = FRAC_BITS + 3;
  localparam int DW = NW + 1;
  localparam int MW = DW + FRAC_BITS + 1;
  localparam int CW = 20;
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (FRAC_BITS - 1);

  logic [4:0] vld;
  logic signed [DW-1:0] d0, d1, d2;
  logic signed [MW-1:0] m0, m1, m2;
  logic signed [MW-1:0] r0, r1, r2;
  logic signed [NW-1:0] b0, b1, ix0, ix1, b2, v;
  logic [FRAC_BITS-1:0] fy8, fy9;
  logic signed [CW-1:0] cv;

  always_comb begin
    d0 = DW'($signed(dot[1])) - DW'($signed(dot[0]));
    d1 = DW'($signed(dot[3])) - DW'($signed(dot[2]));
    d2 = DW'(ix1) - DW'(ix0);
    r0 = (m0 + HALF) >>> FRAC_BITS;
    r1 = (m1 + HALF) >>> FRAC_BITS;
    r2 = (m2 + HALF) >>> FRAC_BITS;
  end

  if (FRAC_BITS > 16) begin : g_down
    logic signed [NW:0] vr;
    assign vr = (NW+1)'(v) + ((NW+1)'(1) <<< (FRAC_BITS - 17));
    assign cv = CW'(vr >>> (FRAC_BITS - 16));
  end else begin : g_up
    assign cv = CW'(v) <<< (16 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m0  <= MW'(d0 * $signed({1'b0, fx}));
      m1  <= MW'(d1 * $signed({1'b0, fx}));
      b0  <= $signed(dot[0]);
      b1  <= $signed(dot[2]);
      fy8 <= fy;

      ix0 <= NW'(MW'(b0) + r0);
      ix1 <= NW'(MW'(b1) + r1);
      fy9 <= fy8;

      m2  <= MW'(d2 * $signed({1'b0, fy9}));
      b2  <= ix0;

      v   <= NW'(MW'(b2) + r2);

      if (cv > CW'(pgn_pkg::ONE_Q16)) begin
        noise_value <= 18'(pgn_pkg::ONE_Q16);
      end else if (cv < -CW'(pgn_pkg::ONE_Q16)) begin
        noise_value <= -18'(pgn_pkg::ONE_Q16);
      end else begin
        noise_value <= 18'(cv);
      end
    end
  end

  assign valid = vld[4];

endmodule

### design/perlin_gradient_noise_2d_core.sv
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_core
// 2D gradient noise: one point in, one saturated Q16 noise value out.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in and out unless the output stalls.
// Four stages form the corner hashes (three 32x32 multiplies), three look up
// gradients and form the dot products, and five interpolate, convert and
// saturate. The whole pipeline advances whenever the output register is
// empty or its result is being taken.
module perlin_gradient_noise_2d_core #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  noise_value
);

`include "perlin_gradient_noise_2d_core_assert.svh"

  logic ce;
  logic h_valid, g_valid;
  logic [3:0][31:0] hash;
  logic [FRAC_BITS-1:0] h_fx, h_fy, g_fx, g_fy;
  logic signed [3:0][FRAC_BITS+2:0] dot;

  assign ce       = out_ready || !out_valid;
  assign in_ready = ce;

  pgn_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(in_valid),
    .coord_x(coord_x), .coord_y(coord_y),
    .valid(h_valid), .hash(hash), .fx(h_fx), .fy(h_fy)
  );

  pgn_grad #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_grad (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(h_valid),
    .hash(hash), .fx_in(h_fx), .fy_in(h_fy),
    .valid(g_valid), .dot(dot), .fx(g_fx), .fy(g_fy)
  );

  pgn_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
    .clk(clk), .rst(rst), .ce(ce), .in_valid(g_valid),
    .dot(dot), .fx(g_fx), .fy(g_fy),
    .valid(out_valid), .noise_value(noise_value)
  );

  `PGN_ASSERT_NOW(a_out_range, out_valid, (noise_value <= 18'sd65536) && (noise_value >= -18'sd65536))
  `PGN_ASSERT_NEXT(a_stall_holds, !ce, $stable(h_valid) && $stable(g_valid))
  `PGN_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(noise_value))

endmodule

### tb/sv/tb_perlin_gradient_noise_2d_core.sv
// ----------------------------------------------------------------------------
// tb_perlin_gradient_noise_2d_core
// Drives random and directed points with bursty input and a stalling output,
// predicts each noise value in fixed point and checks results in order.
// ----------------------------------------------------------------------------
class noise_scoreboard;
  int FRAC = 16;
  int ABITS = 10;
  logic signed [17:0] pending[$];
  int errors;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qsin(longint t);
    longint t2, acc, s;
    t2 = (t * t) >>> 16;
    acc = 64'sd172273;
    acc = -64'sd5026937 + fshift(acc * t2, 16);
    acc = 64'sd85569278 + fshift(acc * t2, 16);
    acc = -64'sd693598669 + fshift(acc * t2, 16);
    acc = 64'sd1686629713 + fshift(acc * t2, 16);
    s = fshift(acc * t + (64'sd1 << 29), 30);
    if (s < 0) s = 0;
    if (s > 65536) s = 65536;
    return s;
  endfunction

  function automatic bit [31:0] mix(longint cx, longint cy);
    bit [31:0] a, b;
    bit [63:0] p;
    a = cx[31:0];
    b = cy[31:0];
    p = a * 64'd3284157443;
    a = p[31:0];
    b ^= {a[15:0], a[31:16]};
    p = b * 64'd1911520717;
    b = p[31:0];
    a ^= {b[15:0], b[31:16]};
    p = a * 64'd2048419325;
    return p[31:0];
  endfunction

  function automatic longint dot(longint cx, longint cy, longint dx, longint dy);
    bit [31:0] h, idx, rem;
    bit [1:0] quad;
    longint t, s, c, gx, gy;
    h = mix(cx, cy);
    idx = h >> (32 - ABITS);
    quad = idx >> (ABITS - 2);
    rem = idx & ((32'd1 << (ABITS - 2)) - 1);
    t = longint'(rem) << (16 - (ABITS - 2));
    s = qsin(t);
    c = qsin(65536 - t);
    case (quad)
      2'd0: begin gx = c; gy = s; end
      2'd1: begin gx = -s; gy = c; end
      2'd2: begin gx = -c; gy = -s; end
      default: begin gx = s; gy = -c; end
    endcase
    return fshift(dx * gx + dy * gy + 32768, 16);
  endfunction

  function automatic longint blend(longint a0, longint a1, longint w);
    return a0 + fshift((a1 - a0) * w + (64'sd1 << (FRAC - 1)), FRAC);
  endfunction

  function void note_point(logic signed [31:0] px, logic signed [31:0] py);
    longint x, y, one, x0, y0, fx, fy, ix0, ix1, v;
    x = px; y = py;
    one = 64'sd1 << FRAC;
    x0 = fshift(x, FRAC);
    y0 = fshift(y, FRAC);
    fx = x - x0 * one;
    fy = y - y0 * one;
    ix0 = blend(dot(x0, y0, fx, fy), dot(x0 + 1, y0, fx - one, fy), fx);
    ix1 = blend(dot(x0, y0 + 1, fx, fy - one), dot(x0 + 1, y0 + 1, fx - one, fy - one), fx);
    v = blend(ix0, ix1, fy);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    pending.push_back(v[17:0]);
  endfunction

  function bit check_noise(logic signed [17:0] got, output logic signed [17:0] want);
    if (pending.size() == 0) begin
      want = 'x;
      return 0;
    end
    want = pending.pop_front();
    return got === want;
  endfunction
endclass

module tb_perlin_gradient_noise_2d_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic signed [31:0] coord_x = 0, coord_y = 0;
  logic signed [17:0] noise_value;
  noise_scoreboard sb = new();
  int cycles = 0;
  int mismatches = 0;
  int stall_mode = 0;
  localparam int LIMIT = 400000;

  perlin_gradient_noise_2d_core dut (.*);

  always #1 clk = ~clk;

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic signed [17:0] want;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (!sb.check_noise(noise_value, want))
        report($sformatf("noise_value got %0d expected %0d", noise_value, want));
    end
    if (cycles > LIMIT) begin
      $display("perlin_gradient_noise_2d_core regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    coord_x <= px;
    coord_y <= py;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_point(px, py);
    @(negedge clk);
  endtask

  task automatic pause_input(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h7ffff) - 32'h40000;
      2: return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom)};
      default: return {16'($urandom_range(0, 7) - 4), 16'($urandom)};
    endcase
  endfunction

  initial begin
    logic signed [31:0] edges[8];
    int burst;
    edges = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh0000ffff, 32'sh00010000,
              -1, 32'sh00008000, 32'shffff0000};
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (edges[i]) begin
      send_point(edges[i], edges[(i + 3) % 8]);
      send_point(edges[i], edges[i]);
    end
    send_point(32'h5555aaaa, 32'haaaa5555);
    pause_input(2);
    for (int n = 0; n < 1900;) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++) send_point(rand_coord(), rand_coord());
      if (n > 900 && n < 960) begin
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0 && sb.pending.size() == 0)
      $display("perlin_gradient_noise_2d_core regression: pass");
    else
      $display("perlin_gradient_noise_2d_core regression: fail");
    $finish;
  end
endmodule
